>>> src/chpd_pkg.sv
// Shared types and constants for the checksum hunt packet deframer.
// No dependencies; imported by every other file of the block.
`default_nettype none

package chpd_pkg;

  localparam int PACKET_BYTES    = 24;
  localparam int PACKET_W        = PACKET_BYTES * 8;
  localparam int FILL_W          = $clog2(PACKET_BYTES);
  localparam int MAX_TEXT_BLOCKS = 256;
  localparam int BLOCK_W         = $clog2(MAX_TEXT_BLOCKS);
  localparam int MARKED_W        = BLOCK_W + 1;

  localparam int HDR_COUNT_BYTE  = 20;
  localparam int BODY_BLOCK_BYTE = 1;

  localparam logic [7:0] SKIP_MAX = 8'hff;

  localparam logic [3:0] NIB_STROKE      = 4'h0;
  localparam logic [3:0] NIB_STROKE_ALT  = 4'h3;
  localparam logic [3:0] NIB_STATUS      = 4'h1;
  localparam logic [3:0] NIB_TIMING      = 4'h2;
  localparam logic [3:0] NIB_TEXT_HEADER = 4'ha;
  localparam logic [3:0] NIB_TEXT_BODY   = 4'hb;

  typedef enum logic [2:0] {
    KIND_STROKE      = 3'd0,
    KIND_STATUS      = 3'd1,
    KIND_TIMING      = 3'd2,
    KIND_TEXT_HEADER = 3'd3,
    KIND_TEXT_BODY   = 3'd4,
    KIND_UNKNOWN     = 3'd5
  } kind_e;

  // packet found by the checksum hunt
  typedef struct packed {
    logic [7:0]          skip;
    logic [PACKET_W-1:0] bytes;
  } pkt_t;

  // decoded result
  typedef struct packed {
    logic [7:0]          skip;
    logic                ready;
    kind_e               kind;
    logic [PACKET_W-1:0] bytes;
  } result_t;

endpackage

`default_nettype wire

>>> src/checksum_hunt_packet_deframer_unit.sv
// Top level of the checksum hunt packet deframer.
// Depends on chpd_pkg, chpd_window and chpd_text.
//
// Input stream: one link byte per request on s_axis_tdata; s_axis_tuser set
// marks a restart request, which empties the window and the skip count and
// drops its byte. Every byte is appended to a 24-byte window; when the full
// window sums to zero mod 256 it is emitted as a packet and the window empties,
// otherwise the oldest byte is dropped and the saturating skip count grows.
// Output stream: one request per packet, with the packet kind on m_axis_tuser.
// Throughput: one byte per cycle while s_axis_tready is high; the window and
// checksum update are registered. A completed packet passes the window result
// register, then the decode and text-block register, which is the output
// register.
// Reset clears the window, skip count, text block count and all block flags;
// no result is pending afterwards.
// When the receiver stalls, one packet waits in the output register and one
// in the window result register; while the window result register holds a
// packet that the decode stage cannot take, s_axis_tready is low.
`default_nettype none

module checksum_hunt_packet_deframer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // in_byte
  input  logic         s_axis_tuser,   // restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bytes_low, bytes_mid, bytes_high, message_ready, skipped_bytes, zero pad
  output logic [207:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser    // packet_kind
);
  import chpd_pkg::*;

  logic    pkt_valid;
  logic    pkt_ready;
  pkt_t    pkt;
  result_t res;

  chpd_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .byte_i     (s_axis_tdata),
    .restart_i  (s_axis_tuser),
    .pkt_valid_o(pkt_valid),
    .pkt_ready_i(pkt_ready),
    .pkt_o      (pkt)
  );

  chpd_text u_text (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_valid_i(pkt_valid),
    .pkt_ready_o(pkt_ready),
    .pkt_i      (pkt),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {7'd0, res.skip, res.ready, res.bytes};
  assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire

>>> src/chpd_window.sv
// Byte window with running checksum; hunts for a zero-sum packet.
// Depends on chpd_pkg. Holds one found packet in its result register.
`default_nettype none

module chpd_window (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [7:0]    byte_i,
  input  logic          restart_i,
  output logic          pkt_valid_o,
  input  logic          pkt_ready_i,
  output chpd_pkg::pkt_t pkt_o
);
  import chpd_pkg::*;

  localparam int LAST = PACKET_BYTES - 1;

  logic [7:0]        win_q [PACKET_BYTES];
  logic [7:0]        win_d [PACKET_BYTES];
  logic [7:0]        full_win [PACKET_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        skip_q, skip_d;
  logic              pkt_valid_q, pkt_valid_d;
  pkt_t              pkt_q, pkt_d;

  logic       accept;
  logic       full;
  logic [7:0] sum_new;

  assign ready_o     = !pkt_valid_q || pkt_ready_i;
  assign accept      = valid_i && ready_o;
  assign full        = (fill_q == FILL_W'(LAST));
  assign sum_new     = sum_q + byte_i;
  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

  always_comb begin
    for (int i = 0; i < LAST; i++) begin
      full_win[i] = win_q[i];
    end
    full_win[LAST] = byte_i;
  end

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    skip_d      = skip_q;
    pkt_d       = pkt_q;
    pkt_valid_d = pkt_valid_q && !pkt_ready_i;
    if (accept) begin
      if (restart_i) begin
        fill_d = '0;
        sum_d  = '0;
        skip_d = '0;
      end else if (!full) begin
        for (int i = 0; i < PACKET_BYTES; i++) begin
          if (fill_q == FILL_W'(i)) begin
            win_d[i] = byte_i;
          end
        end
        fill_d = fill_q + FILL_W'(1);
        sum_d  = sum_new;
      end else if (sum_new != 8'd0) begin
        // drop oldest byte, keep hunting
        for (int i = 0; i < LAST; i++) begin
          win_d[i] = full_win[i+1];
        end
        sum_d = sum_new - win_q[0];
        if (skip_q != SKIP_MAX) begin
          skip_d = skip_q + 8'd1;
        end
      end else begin
        for (int i = 0; i < PACKET_BYTES; i++) begin
          pkt_d.bytes[8*i +: 8] = full_win[i];
        end
        pkt_d.skip  = skip_q;
        pkt_valid_d = 1'b1;
        fill_d      = '0;
        sum_d       = '0;
        skip_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sum_q       <= '0;
      skip_q      <= '0;
      pkt_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      skip_q      <= skip_d;
      pkt_valid_q <= pkt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    pkt_q <= pkt_d;
  end

endmodule

`default_nettype wire

>>> src/chpd_text.sv
// Packet kind decode and text block bookkeeping, plus the output register.
// Depends on chpd_pkg; fed by chpd_window.
`default_nettype none

module chpd_text (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pkt_valid_i,
  output logic              pkt_ready_o,
  input  chpd_pkg::pkt_t    pkt_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output chpd_pkg::result_t res_o
);
  import chpd_pkg::*;

  logic [MAX_TEXT_BLOCKS-1:0] seen_q, seen_d;
  logic [7:0]                 total_q, total_d;
  logic [MARKED_W-1:0]        marked_q, marked_d;
  logic                       out_valid_q, out_valid_d;
  result_t                    res_q, res_d;

  logic             take;
  logic [3:0]       nib;
  logic [7:0]       hdr_count;
  logic [7:0]       blk_num;
  logic [BLOCK_W-1:0] blk;
  logic             blk_ok;

  assign pkt_ready_o = !out_valid_q || out_ready_i;
  assign take        = pkt_valid_i && pkt_ready_o;
  assign nib         = pkt_i.bytes[3:0];
  assign hdr_count   = pkt_i.bytes[8*HDR_COUNT_BYTE +: 8];
  assign blk_num     = pkt_i.bytes[8*BODY_BLOCK_BYTE +: 8];
  assign blk         = BLOCK_W'(blk_num - 8'd1);
  assign blk_ok      = (blk_num != 8'd0) && ({1'b0, blk} < {1'b0, total_q});
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    seen_d      = seen_q;
    total_d     = total_q;
    marked_d    = marked_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      res_d.bytes = pkt_i.bytes;
      res_d.skip  = pkt_i.skip;
      out_valid_d = 1'b1;
      case (nib)
        NIB_STROKE, NIB_STROKE_ALT: begin
          res_d.kind  = KIND_STROKE;
          res_d.ready = 1'b1;
        end
        NIB_STATUS: begin
          res_d.kind  = KIND_STATUS;
          res_d.ready = 1'b1;
        end
        NIB_TIMING: begin
          res_d.kind  = KIND_TIMING;
          res_d.ready = 1'b1;
        end
        NIB_TEXT_HEADER: begin
          res_d.kind  = KIND_TEXT_HEADER;
          total_d     = hdr_count;
          seen_d      = '0;
          marked_d    = '0;
          res_d.ready = (hdr_count == 8'd0);
        end
        NIB_TEXT_BODY: begin
          res_d.kind = KIND_TEXT_BODY;
          if (blk_ok && !seen_q[blk]) begin
            seen_d[blk] = 1'b1;
            marked_d    = marked_q + MARKED_W'(1);
          end
          res_d.ready = (marked_d == MARKED_W'(total_q));
        end
        default: begin
          res_d.kind  = KIND_UNKNOWN;
          res_d.ready = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      total_q     <= '0;
      marked_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      total_q     <= total_d;
      marked_q    <= marked_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for checksum_hunt_packet_deframer_unit.
// Depends on chpd_pkg and the deframer RTL. Framed packets, noise and restarts
// go in; each emitted packet is checked against an in-bench deframer predictor.
module testbench;
  import chpd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 480;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       drain;
  } link_req_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] mid;
    logic [63:0] hi;
    kind_e       kind;
    logic        ready;
    logic [7:0]  skip;
  } frame_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  link_req_t link_q[$];
  frame_t    frames_due_q[$];
  link_req_t next_req;
  int        n_items = 0;
  int        errors = 0;
  int        cycle_cnt = 0;
  int        src_gap = 0;
  int        snk_gap = 0;
  logic      calm;

  // deframer predictor state
  logic [7:0] win [PACKET_BYTES];
  int         win_fill = 0;
  logic [7:0] win_sum = '0;
  logic [7:0] hunt_skip = '0;
  logic [7:0] blk_total = '0;
  logic       blk_seen [MAX_TEXT_BLOCKS];
  logic [8:0] blk_marked = '0;

  checksum_hunt_packet_deframer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  assign calm = (cycle_cnt[9:8] == 2'b11);

  function automatic int draw_gap(input logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic clear_window();
    for (int i = 0; i < PACKET_BYTES; i++) win[i] = '0;
    win_fill = 0;
    win_sum = '0;
  endtask

  task automatic hunt_byte(input logic [7:0] b, input logic restart);
    frame_t f;
    logic [3:0] nib;
    int bn;
    if (restart) begin
      clear_window();
      hunt_skip = '0;
      return;
    end
    win[win_fill] = b;
    win_fill++;
    win_sum = win_sum + b;
    if (win_fill < PACKET_BYTES) return;
    if (win_sum != 8'h00) begin
      win_sum = win_sum - win[0];
      for (int i = 0; i < PACKET_BYTES - 1; i++) win[i] = win[i+1];
      win[PACKET_BYTES-1] = '0;
      win_fill = PACKET_BYTES - 1;
      if (hunt_skip != SKIP_MAX) hunt_skip++;
      return;
    end
    nib = win[0][3:0];
    f.ready = 1'b1;
    case (nib)
      NIB_STROKE, NIB_STROKE_ALT: f.kind = KIND_STROKE;
      NIB_STATUS: f.kind = KIND_STATUS;
      NIB_TIMING: f.kind = KIND_TIMING;
      NIB_TEXT_HEADER: begin
        f.kind = KIND_TEXT_HEADER;
        blk_total = win[HDR_COUNT_BYTE];
        for (int i = 0; i < MAX_TEXT_BLOCKS; i++) blk_seen[i] = 1'b0;
        blk_marked = '0;
        f.ready = (blk_total == 8'h00);
      end
      NIB_TEXT_BODY: begin
        f.kind = KIND_TEXT_BODY;
        bn = win[BODY_BLOCK_BYTE];
        if (bn >= 1 && (bn - 1) < int'(blk_total) && !blk_seen[bn-1]) begin
          blk_seen[bn-1] = 1'b1;
          blk_marked = blk_marked + 9'd1;
        end
        f.ready = (blk_marked == {1'b0, blk_total});
      end
      default: begin
        f.kind = KIND_UNKNOWN;
        f.ready = 1'b0;
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      f.lo[8*i +: 8]  = win[i];
      f.mid[8*i +: 8] = win[8+i];
      f.hi[8*i +: 8]  = win[16+i];
    end
    f.skip = hunt_skip;
    frames_due_q.push_back(f);
    clear_window();
    hunt_skip = '0;
  endtask

  task automatic check_frame();
    frame_t want;
    logic bad;
    if (frames_due_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected packet: tdata=%h tuser=%0d", m_axis_tdata, m_axis_tuser);
      return;
    end
    want = frames_due_q.pop_front();
    bad = (m_axis_tdata[63:0] !== want.lo) || (m_axis_tdata[127:64] !== want.mid) ||
          (m_axis_tdata[191:128] !== want.hi) || (m_axis_tdata[192] !== want.ready) ||
          (m_axis_tdata[200:193] !== want.skip) || (m_axis_tdata[207:201] !== 7'd0) ||
          (m_axis_tuser !== want.kind);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch exp: lo=%h mid=%h hi=%h kind=%0d ready=%b skip=%0d",
                 want.lo, want.mid, want.hi, want.kind, want.ready, want.skip);
        $display("         got: lo=%h mid=%h hi=%h kind=%0d ready=%b skip=%0d pad=%h",
                 m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tdata[191:128],
                 m_axis_tuser, m_axis_tdata[192], m_axis_tdata[200:193],
                 m_axis_tdata[207:201]);
      end
    end
  endtask

  // source side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) hunt_byte(s_axis_tdata, s_axis_tuser);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (link_q.size() > 0 && !(link_q[0].drain && frames_due_q.size() > 0)) begin
          next_req = link_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_req.data;
          s_axis_tuser  <= next_req.restart;
          src_gap = draw_gap(calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_frame();
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        snk_gap = draw_gap(calm);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_req(input logic [7:0] b, input logic restart, input logic drain);
    link_q.push_back('{data: b, restart: restart, drain: drain});
    n_items++;
  endtask

  // fill: 0 random, 1 all zero, 2 all ones; byte 23 closes the checksum
  task automatic add_packet(input logic [3:0] nib, input logic [7:0] b1, input logic [7:0] b20,
                            input int fill, input int keep, input logic drain);
    logic [7:0] pk [PACKET_BYTES];
    logic [7:0] s;
    for (int i = 0; i < PACKET_BYTES; i++)
      pk[i] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom_range(0, 255));
    pk[0][3:0] = nib;
    pk[BODY_BLOCK_BYTE] = b1;
    pk[HDR_COUNT_BYTE] = b20;
    s = '0;
    for (int i = 0; i < PACKET_BYTES - 1; i++) s = s + pk[i];
    pk[PACKET_BYTES-1] = -s;
    for (int i = 0; i < keep; i++) push_req(pk[i], 1'b0, drain && i == 0);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int base;
    int r;
    int k;
    logic sat_done;

    // directed
    add_packet(NIB_STROKE, 8'h00, 8'h00, 1, PACKET_BYTES, 1'b0);
    add_packet(4'hf, 8'hff, 8'hff, 2, PACKET_BYTES, 1'b0);
    add_packet(NIB_STROKE_ALT, rnd8(), rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_STATUS, rnd8(), rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TIMING, rnd8(), rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_BODY, 8'd1, rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_HEADER, rnd8(), 8'd0, 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_HEADER, rnd8(), 8'd2, 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_BODY, 8'd1, rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_BODY, 8'd1, rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_BODY, 8'd0, rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_BODY, 8'd3, rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_BODY, 8'd2, rnd8(), 0, PACKET_BYTES, 1'b0);
    add_packet(4'h7, rnd8(), rnd8(), 0, PACKET_BYTES, 1'b0);
    push_req(8'hff, 1'b1, 1'b0);
    add_packet(NIB_STATUS, rnd8(), rnd8(), 0, 10, 1'b0);
    push_req(8'h00, 1'b1, 1'b0);
    add_packet(NIB_TIMING, rnd8(), rnd8(), 0, PACKET_BYTES, 1'b0);
    add_noise(5);
    add_packet(NIB_STROKE, rnd8(), rnd8(), 0, PACKET_BYTES, 1'b1);
    add_packet(NIB_TEXT_HEADER, rnd8(), 8'd255, 0, PACKET_BYTES, 1'b0);
    add_packet(NIB_TEXT_BODY, 8'd255, rnd8(), 0, PACKET_BYTES, 1'b0);

    // random
    base = n_items;
    sat_done = 1'b0;
    while (n_items - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (!sat_done && n_items - base > RANDOM_ITEMS / 3) begin
        // a long run that never checks out drives the skip count into saturation
        sat_done = 1'b1;
        push_req(8'h01, 1'b0, 1'b1);
        for (int i = 0; i < 300; i++) push_req(8'h01, 1'b0, 1'b0);
        add_packet(4'($urandom_range(0, 15)), rnd8(), rnd8(), 0, PACKET_BYTES, 1'b0);
      end else if (r < 45) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        add_packet(NIB_TEXT_HEADER, rnd8(), 8'(k), 0, PACKET_BYTES,
                   $urandom_range(0, 29) == 0);
        for (int j = 0; j < ((k > 8) ? 8 : k) + 1; j++) begin
          if ($urandom_range(0, 6) == 0) add_noise($urandom_range(1, 5));
          add_packet(NIB_TEXT_BODY, 8'($urandom_range(0, (k > 254) ? 255 : k + 1)), rnd8(),
                     0, PACKET_BYTES, 1'b0);
        end
      end else if (r < 75) begin
        add_packet(4'($urandom_range(0, 15)), rnd8(), rnd8(), 0, PACKET_BYTES,
                   $urandom_range(0, 29) == 0);
      end else if (r < 87) begin
        add_noise($urandom_range(1, 30));
      end else if (r < 95) begin
        add_packet(4'($urandom_range(0, 15)), rnd8(), rnd8(), 0, $urandom_range(1, 23), 1'b0);
        push_req(rnd8(), 1'b1, 1'b0);
      end else begin
        push_req(rnd8(), 1'b1, 1'b0);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (link_q.size() != 0 || s_axis_tvalid || frames_due_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && frames_due_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
